[src/ccc_pkg.sv]
// Calendar clock counter: shared types, constants and calendar helper functions.
// Used by the front end, the queue and the back end; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

  // request codes
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [15:0] TPS_RESET   = 16'd1000;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_MAR   = 4'd3;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  DAY_DEC_END = 5'd31;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [5:0]  MIN_LAST    = 6'd59;
  localparam logic [5:0]  SEC_LAST    = 6'd59;
  localparam logic [2:0]  WD_MONDAY   = 3'd1;
  localparam logic [2:0]  WD_SATURDAY = 3'd6;
  localparam logic [2:0]  WD_SUNDAY   = 3'd7;
  localparam logic [6:0]  MOD100_LAST = 7'd99;
  localparam logic [6:0]  CENTURY     = 7'd100;

  // floor(x / 100) = (x * 5243) >> 19, exact for any 14-bit x
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // one classified word as it travels from front end to back end
  typedef struct packed {
    logic        is_load;
    logic        err;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [6:0]  yr_mod100;
    logic [1:0]  yr_cent;   // (year / 100) mod 4
  } ccc_entry_t;

  // year % 4 == 0 and (year % 100 != 0 or year % 400 == 0)
  function automatic logic is_leap(input logic [1:0] yr_low, input logic [6:0] mod100,
                                   input logic [1:0] cent);
    is_leap = (yr_low == 2'd0) && ((mod100 != 7'd0) || (cent == 2'd0));
  endfunction

  // zero for a month code outside 1..12
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   month_days = 5'd30;
      MONTH_FEB:                                 month_days = leap ? 5'd29 : 5'd28;
      default:                                   month_days = 5'd0;
    endcase
  endfunction

  // month offsets of the Sakamoto weekday formula
  function automatic logic [2:0] sak_offset(input logic [3:0] month);
    unique case (month)
      4'd1:    sak_offset = 3'd0;
      4'd2:    sak_offset = 3'd3;
      4'd3:    sak_offset = 3'd2;
      4'd4:    sak_offset = 3'd5;
      4'd5:    sak_offset = 3'd0;
      4'd6:    sak_offset = 3'd3;
      4'd7:    sak_offset = 3'd5;
      4'd8:    sak_offset = 3'd1;
      4'd9:    sak_offset = 3'd4;
      4'd10:   sak_offset = 3'd6;
      4'd11:   sak_offset = 3'd2;
      4'd12:   sak_offset = 3'd4;
      default: sak_offset = 3'd0;
    endcase
  endfunction

  // sum mod 7 mapped to 1..7 (0 -> Sunday); 8 = 1 mod 7, so octal digits fold
  function automatic logic [2:0] weekday_fold(input logic [15:0] sum);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9])
       + 6'(sum[14:12]) + 6'(sum[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    weekday_fold = ((s3 == 4'd0) || (s3 == 4'd7)) ? WD_SUNDAY : s3[2:0];
  endfunction

endpackage

`default_nettype wire

[src/ccc_front.sv]
// Calendar clock counter front end: two-stage pipeline that accepts words, validates
// loads and derives leap data and weekday. Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic [13:0]        in_load_year,
  input  wire logic [3:0]         in_load_month,
  input  wire logic [4:0]         in_load_day,
  input  wire logic [4:0]         in_load_hour,
  input  wire logic [5:0]         in_load_minute,
  input  wire logic [5:0]         in_load_second,
  input  wire logic               q_full,
  output logic                    q_push,
  output ccc_pkg::ccc_entry_t     q_wdata
);

  // stage 1: captured word
  logic        f1_v_r;
  logic        f1_type_r;
  logic [13:0] f1_year_r;
  logic [3:0]  f1_month_r;
  logic [4:0]  f1_day_r;
  logic [4:0]  f1_hour_r;
  logic [5:0]  f1_minute_r;
  logic [5:0]  f1_second_r;

  // stage 2: quotients by 100
  logic        f2_v_r;
  logic        f2_type_r;
  logic [13:0] f2_year_r;
  logic [13:0] f2_ya_r;
  logic [7:0]  f2_q100y_r;
  logic [7:0]  f2_qa100_r;
  logic [3:0]  f2_month_r;
  logic [4:0]  f2_day_r;
  logic [4:0]  f2_hour_r;
  logic [5:0]  f2_minute_r;
  logic [5:0]  f2_second_r;

  logic        f1_free;
  logic        f2_free;
  logic [13:0] ya;
  logic [26:0] prod_y;
  logic [26:0] prod_ya;
  logic [13:0] r100;
  logic        leap;
  logic [4:0]  mdays;
  logic [15:0] wd_sum;
  logic        bad;

  assign f2_free  = !f2_v_r || !q_full;
  assign f1_free  = !f1_v_r || f2_free;
  assign in_ready = f1_free;

  // Sakamoto shifts Jan/Feb into the previous year
  assign ya      = (f1_month_r < ccc_pkg::MONTH_MAR) ? (f1_year_r - 14'd1) : f1_year_r;
  assign prod_y  = 27'(f1_year_r) * 27'(ccc_pkg::DIV100_MUL);
  assign prod_ya = 27'(ya) * 27'(ccc_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (f1_free) begin
        f1_v_r <= in_valid;
      end
      if (f2_free) begin
        f2_v_r <= f1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_free && in_valid) begin
      f1_type_r   <= in_req_type;
      f1_year_r   <= in_load_year;
      f1_month_r  <= in_load_month;
      f1_day_r    <= in_load_day;
      f1_hour_r   <= in_load_hour;
      f1_minute_r <= in_load_minute;
      f1_second_r <= in_load_second;
    end
    if (f2_free && f1_v_r) begin
      f2_type_r   <= f1_type_r;
      f2_year_r   <= f1_year_r;
      f2_ya_r     <= ya;
      f2_q100y_r  <= prod_y[ccc_pkg::DIV100_SHIFT +: 8];
      f2_qa100_r  <= prod_ya[ccc_pkg::DIV100_SHIFT +: 8];
      f2_month_r  <= f1_month_r;
      f2_day_r    <= f1_day_r;
      f2_hour_r   <= f1_hour_r;
      f2_minute_r <= f1_minute_r;
      f2_second_r <= f1_second_r;
    end
  end

  // stage 2 logic: range check and weekday
  assign r100  = f2_year_r - 14'(f2_q100y_r) * 14'(ccc_pkg::CENTURY);
  assign leap  = ccc_pkg::is_leap(f2_year_r[1:0], r100[6:0], f2_q100y_r[1:0]);
  assign mdays = ccc_pkg::month_days(leap, f2_month_r);

  assign bad = (f2_year_r == 14'd0) || (f2_year_r > ccc_pkg::YEAR_MAX) ||
               (f2_month_r < ccc_pkg::MONTH_FIRST) || (f2_month_r > ccc_pkg::MONTH_LAST) ||
               (f2_day_r < ccc_pkg::DAY_FIRST) || (f2_day_r > mdays) ||
               (f2_hour_r > ccc_pkg::HOUR_LAST) || (f2_minute_r > ccc_pkg::MIN_LAST) ||
               (f2_second_r > ccc_pkg::SEC_LAST);

  // y + y/4 - y/100 + y/400 + offset + d, with y/400 = (y/100)/4
  assign wd_sum = 16'(f2_ya_r) + 16'(f2_ya_r[13:2]) - 16'(f2_qa100_r)
                + 16'(f2_qa100_r[7:2]) + 16'(ccc_pkg::sak_offset(f2_month_r))
                + 16'(f2_day_r);

  assign q_push = f2_v_r && !q_full;

  always_comb begin
    q_wdata           = '0;
    q_wdata.is_load   = (f2_type_r == ccc_pkg::REQ_LOAD);
    q_wdata.err       = bad;
    q_wdata.year      = f2_year_r;
    q_wdata.month     = f2_month_r;
    q_wdata.day       = f2_day_r;
    q_wdata.hour      = f2_hour_r;
    q_wdata.minute    = f2_minute_r;
    q_wdata.second    = f2_second_r;
    q_wdata.weekday   = ccc_pkg::weekday_fold(wd_sum);
    q_wdata.yr_mod100 = r100[6:0];
    q_wdata.yr_cent   = f2_q100y_r[1:0];
  end

endmodule

`default_nettype wire

[src/ccc_queue.sv]
// Calendar clock counter queue: small register FIFO of classified words between
// the front end and the back end. Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire ccc_pkg::ccc_entry_t  wdata,
  input  wire logic                 pop,
  output ccc_pkg::ccc_entry_t       rdata,
  output logic                      full,
  output logic                      empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccc_pkg::ccc_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                push_ok;
  logic                pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[src/ccc_back.sv]
// Calendar clock counter back end: holds the prescaler and calendar, applies one
// word per cycle when not stalled and registers the result word. Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [15:0]          cfg_wr_data,
  input  wire logic                 q_empty,
  input  wire ccc_pkg::ccc_entry_t  q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [13:0]               out_year,
  output logic [3:0]                out_month,
  output logic [4:0]                out_day,
  output logic [4:0]                out_hour,
  output logic [5:0]                out_minute,
  output logic [5:0]                out_second,
  output logic [2:0]                out_weekday,
  output logic                      out_second_advanced,
  output logic                      out_load_error
);

  logic [15:0] tps_r;
  logic [15:0] tick_r,   tick_nxt;
  logic [13:0] year_r,   year_nxt;
  logic [3:0]  month_r,  month_nxt;
  logic [4:0]  day_r,    day_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  min_r,    min_nxt;
  logic [5:0]  sec_r,    sec_nxt;
  logic [2:0]  wd_r,     wd_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [1:0]  cent_r,   cent_nxt;
  logic        adv_nxt;
  logic        err_nxt;
  logic        out_v_r;

  logic [15:0] limit;
  logic [16:0] tick_inc;
  logic        at_last;
  logic        leap_cur;

  assign q_pop     = !q_empty && (!out_v_r || out_ready);
  assign out_valid = out_v_r;

  assign limit    = (tps_r == 16'd0) ? 16'd1 : tps_r;
  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign leap_cur = ccc_pkg::is_leap(year_r[1:0], mod100_r, cent_r);
  assign at_last  = (year_r == ccc_pkg::YEAR_MAX) && (month_r == ccc_pkg::MONTH_LAST) &&
                    (day_r == ccc_pkg::DAY_DEC_END) && (hour_r == ccc_pkg::HOUR_LAST) &&
                    (min_r == ccc_pkg::MIN_LAST) && (sec_r == ccc_pkg::SEC_LAST);

  always_comb begin
    tick_nxt   = tick_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    wd_nxt     = wd_r;
    mod100_nxt = mod100_r;
    cent_nxt   = cent_r;
    adv_nxt    = 1'b0;
    err_nxt    = 1'b0;
    if (!q_rdata.is_load) begin
      if (tick_inc >= {1'b0, limit}) begin
        tick_nxt = '0;
        // calendar holds at the very last second of year 9999
        if (!at_last) begin
          adv_nxt = 1'b1;
          if (sec_r < ccc_pkg::SEC_LAST) begin
            sec_nxt = sec_r + 6'd1;
          end else begin
            sec_nxt = '0;
            if (min_r < ccc_pkg::MIN_LAST) begin
              min_nxt = min_r + 6'd1;
            end else begin
              min_nxt = '0;
              if (hour_r < ccc_pkg::HOUR_LAST) begin
                hour_nxt = hour_r + 5'd1;
              end else begin
                hour_nxt = '0;
                wd_nxt   = (wd_r >= ccc_pkg::WD_SUNDAY) ? ccc_pkg::WD_MONDAY : wd_r + 3'd1;
                if (day_r < ccc_pkg::month_days(leap_cur, month_r)) begin
                  day_nxt = day_r + 5'd1;
                end else begin
                  day_nxt = ccc_pkg::DAY_FIRST;
                  if (month_r < ccc_pkg::MONTH_LAST) begin
                    month_nxt = month_r + 4'd1;
                  end else begin
                    month_nxt = ccc_pkg::MONTH_FIRST;
                    year_nxt  = year_r + 14'd1;
                    if (mod100_r == ccc_pkg::MOD100_LAST) begin
                      mod100_nxt = '0;
                      cent_nxt   = cent_r + 2'd1;
                    end else begin
                      mod100_nxt = mod100_r + 7'd1;
                    end
                  end
                end
              end
            end
          end
        end
      end else begin
        tick_nxt = tick_inc[15:0];
      end
    end else if (q_rdata.err) begin
      err_nxt = 1'b1;
    end else begin
      tick_nxt   = '0;
      year_nxt   = q_rdata.year;
      month_nxt  = q_rdata.month;
      day_nxt    = q_rdata.day;
      hour_nxt   = q_rdata.hour;
      min_nxt    = q_rdata.minute;
      sec_nxt    = q_rdata.second;
      wd_nxt     = q_rdata.weekday;
      mod100_nxt = q_rdata.yr_mod100;
      cent_nxt   = q_rdata.yr_cent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r    <= ccc_pkg::TPS_RESET;
      tick_r   <= '0;
      year_r   <= ccc_pkg::YEAR_RESET;
      month_r  <= ccc_pkg::MONTH_FIRST;
      day_r    <= ccc_pkg::DAY_FIRST;
      hour_r   <= '0;
      min_r    <= '0;
      sec_r    <= '0;
      wd_r     <= ccc_pkg::WD_SATURDAY;
      mod100_r <= '0;   // 2000 mod 100
      cent_r   <= '0;   // 20 mod 4
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tps_r <= cfg_wr_data;
      end
      if (q_pop) begin
        tick_r   <= tick_nxt;
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        min_r    <= min_nxt;
        sec_r    <= sec_nxt;
        wd_r     <= wd_nxt;
        mod100_r <= mod100_nxt;
        cent_r   <= cent_nxt;
        out_v_r  <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_year            <= year_nxt;
      out_month           <= month_nxt;
      out_day             <= day_nxt;
      out_hour            <= hour_nxt;
      out_minute          <= min_nxt;
      out_second          <= sec_nxt;
      out_weekday         <= wd_nxt;
      out_second_advanced <= adv_nxt;
      out_load_error      <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[src/calendar_clock_counter_unit.sv]
// Calendar clock counter top level: front end, word queue and back end.
// Depends on ccc_pkg, ccc_front, ccc_queue and ccc_back.
//
// Gregorian calendar clock driven by tick and load words. Each accepted word yields
// one result word with the date and time after it. One word per cycle is sustained
// while the result port is not stalled. A word passes through registers in order:
// the accepting edge captures the word, then come a front-end stage that validates
// loads and computes the weekday, a queue write, and the back-end update, which
// applies one word per cycle when not stalled to the calendar state. The QUEUE_DEPTH-entry
// queue lets the front end keep accepting while the result port is stalled. Write
// ticks_per_second through cfg_wr_en/cfg_wr_data only while no words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_counter_unit #(
  parameter int QUEUE_DEPTH = 4   // 2 or more
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [13:0] in_load_year,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [4:0]  in_load_hour,
  input  wire logic [5:0]  in_load_minute,
  input  wire logic [5:0]  in_load_second,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday,
  output logic             out_second_advanced,
  output logic             out_load_error
);

  ccc_pkg::ccc_entry_t q_wdata;
  ccc_pkg::ccc_entry_t q_rdata;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;

  ccc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_load_year   (in_load_year),
    .in_load_month  (in_load_month),
    .in_load_day    (in_load_day),
    .in_load_hour   (in_load_hour),
    .in_load_minute (in_load_minute),
    .in_load_second (in_load_second),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  ccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ccc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_empty             (q_empty),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_year            (out_year),
    .out_month           (out_month),
    .out_day             (out_day),
    .out_hour            (out_hour),
    .out_minute          (out_minute),
    .out_second          (out_second),
    .out_weekday         (out_weekday),
    .out_second_advanced (out_second_advanced),
    .out_load_error      (out_load_error)
  );

endmodule

`default_nettype wire

[src/ccc_checker.sv]
// Calendar clock counter port checker and its bind to the top level.
// Watches only top-level ports; depends on calendar_clock_counter_unit.
`timescale 1ns / 1ps
`default_nettype none

module ccc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [13:0] out_year,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day,
  input wire logic [4:0]  out_hour,
  input wire logic [5:0]  out_minute,
  input wire logic [5:0]  out_second,
  input wire logic [2:0]  out_weekday,
  input wire logic        out_second_advanced,
  input wire logic        out_load_error
);

  // no result word survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // a stalled result word holds its year, month, day, second and weekday
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month) &&
      $stable(out_day) && $stable(out_second) && $stable(out_weekday))
    else $error("stalled result word changed");

  // a word is either a tick or a load, never both flags
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_second_advanced && out_load_error))
    else $error("advance and load error both set");

  // the calendar never leaves its legal ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_weekday != 3'd0) && (out_month != 4'd0) && (out_month <= 4'd12) &&
      (out_day != 5'd0) && (out_hour <= 5'd23) && (out_minute <= 6'd59) &&
      (out_second <= 6'd59) && (out_year != 14'd0) && (out_year <= 14'd9999))
    else $error("calendar field out of range");

endmodule

bind calendar_clock_counter_unit ccc_checker u_ccc_checker (.*);

`default_nettype wire
